/* hw/rtl/psrst_pkg.sv */
package psrst_pkg;

  localparam int unsigned DEF_LEAVES = 1024;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned DATA_W     = 32;

  typedef enum logic {
    OP_SET   = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic set_leaf;
    logic set_up;
    logic query;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic leaf_ok;
    logic at_root;
    logic range_done;
  } dp_sts_t;

endpackage

/* hw/rtl/point_set_range_sum_tree.sv */
// Set word: busy for up to 1 + ceil(log2(LEAVES)) cycles (11 at 1024 leaves), one tree level
// per cycle through the node RAM's write port and one read port. No result word.
// Sum word: busy for up to log2(2*LEAVES) + 1 cycles (12 at 1024 leaves), both range borders
// climb together on the two RAM read ports; done_o pulses for one cycle right after busy_o falls.
// Reset: busy for 2*LEAVES cycles while the node RAM is swept to zero. done_o is never stalled.
module point_set_range_sum_tree import psrst_pkg::*; #(
  parameter int unsigned LEAVES = DEF_LEAVES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     operation_i,
  input  logic [IDX_W-1:0]         left_index_i,
  input  logic [IDX_W-1:0]         right_index_i,
  input  logic signed [DATA_W-1:0] leaf_value_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] range_sum_o,
  output logic                     bad_range_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  psrst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .done_o      (done_o)
  );

  psrst_dp #(
    .LEAVES(LEAVES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .left_index_i  (left_index_i),
    .right_index_i (right_index_i),
    .leaf_value_i  (leaf_value_i),
    .range_sum_o   (range_sum_o),
    .bad_range_o   (bad_range_o)
  );

endmodule

/* hw/rtl/psrst_ram.sv */
module psrst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* hw/rtl/psrst_dp.sv */
module psrst_dp import psrst_pkg::*; #(
  parameter int unsigned LEAVES = DEF_LEAVES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_sts_t                  sts_o,
  input  logic                     operation_i,
  input  logic [IDX_W-1:0]         left_index_i,
  input  logic [IDX_W-1:0]         right_index_i,
  input  logic signed [DATA_W-1:0] leaf_value_i,
  output logic signed [DATA_W-1:0] range_sum_o,
  output logic                     bad_range_o
);

  localparam int unsigned NW = $clog2(2 * LEAVES);
  localparam int unsigned XW = NW + 1;
  localparam int unsigned CW = (XW > IDX_W + 1) ? XW : IDX_W + 1;
  localparam logic [XW-1:0] LastNode = XW'(2 * LEAVES - 1);
  localparam logic [XW-1:0] RootNode = XW'(1);
  localparam logic [CW-1:0] LeafBaseC = CW'(LEAVES);
  localparam logic [CW-1:0] LastLeafC = CW'(LEAVES - 1);

  logic [XW-1:0]     lo_q, lo_d;
  logic [XW-1:0]     hi_q, hi_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic              pend_lo_q, pend_lo_d;
  logic              pend_hi_q, pend_hi_d;
  logic              leaf_ok_q, leaf_ok_d;
  logic              bad_q, bad_d;

  logic [CW-1:0]     left_c, right_c, rsat_c, lo_c, hi_c;
  logic              empty;
  logic [XW-1:0]     parent;
  logic [XW-1:0]     hi_m1;
  logic              active;
  logic [DATA_W-1:0] up_sum;

  logic              we;
  logic [NW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [NW-1:0]     raddr_a, raddr_b;
  logic [DATA_W-1:0] rdata_a, rdata_b;

  // saturate the range end and form the half-open node bounds
  assign left_c  = CW'(left_index_i);
  assign right_c = CW'(right_index_i);
  assign rsat_c  = (right_c > LastLeafC) ? LastLeafC : right_c;
  assign empty   = left_c > rsat_c;
  assign lo_c    = LeafBaseC + left_c;
  assign hi_c    = LeafBaseC + rsat_c + CW'(1);

  assign parent = lo_q >> 1;
  assign hi_m1  = hi_q - XW'(1);
  assign active = lo_q < hi_q;
  assign up_sum = acc_q + rdata_a;

  always_comb begin
    lo_d      = lo_q;
    hi_d      = hi_q;
    acc_d     = acc_q;
    pend_lo_d = pend_lo_q;
    pend_hi_d = pend_hi_q;
    leaf_ok_d = leaf_ok_q;
    bad_d     = bad_q;
    we        = 1'b0;
    waddr     = lo_q[NW-1:0];
    wdata     = acc_q;
    raddr_a   = lo_q[NW-1:0];
    raddr_b   = hi_m1[NW-1:0];

    if (cmd_i.load) begin
      hi_d      = hi_c[XW-1:0];
      lo_d      = (operation_i == OP_QUERY && empty) ? hi_c[XW-1:0] : lo_c[XW-1:0];
      acc_d     = (operation_i == OP_SET) ? leaf_value_i : '0;
      pend_lo_d = 1'b0;
      pend_hi_d = 1'b0;
      leaf_ok_d = left_c < LeafBaseC;
      bad_d     = left_index_i > right_index_i;
    end

    if (cmd_i.clear) begin
      we    = 1'b1;
      wdata = '0;
      lo_d  = lo_q + XW'(1);
    end

    if (cmd_i.set_leaf) begin
      we      = leaf_ok_q;
      raddr_a = lo_q[NW-1:0] ^ NW'(1);
    end

    // combine with the sibling read last cycle, write the parent
    if (cmd_i.set_up) begin
      we      = 1'b1;
      waddr   = parent[NW-1:0];
      wdata   = up_sum;
      acc_d   = up_sum;
      lo_d    = parent;
      raddr_a = parent[NW-1:0] ^ NW'(1);
    end

    if (cmd_i.query) begin
      acc_d = acc_q + (pend_lo_q ? rdata_a : '0) + (pend_hi_q ? rdata_b : '0);
      pend_lo_d = active & lo_q[0];
      pend_hi_d = active & hi_q[0];
      if (active) begin
        lo_d = (lo_q + XW'(lo_q[0])) >> 1;
        hi_d = (hi_q - XW'(hi_q[0])) >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q      <= '0;
      pend_lo_q <= 1'b0;
      pend_hi_q <= 1'b0;
      leaf_ok_q <= 1'b0;
    end else begin
      lo_q      <= lo_d;
      pend_lo_q <= pend_lo_d;
      pend_hi_q <= pend_hi_d;
      leaf_ok_q <= leaf_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q  <= hi_d;
    acc_q <= acc_d;
    bad_q <= bad_d;
  end

  psrst_ram #(
    .WIDTH(DATA_W),
    .DEPTH(2 * LEAVES)
  ) u_node_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  assign sts_o.clear_last = lo_q == LastNode;
  assign sts_o.leaf_ok    = leaf_ok_q;
  assign sts_o.at_root    = parent == RootNode;
  assign sts_o.range_done = !active;

  assign range_sum_o = acc_q;
  assign bad_range_o = bad_q;

endmodule

/* hw/rtl/psrst_ctrl.sv */
module psrst_ctrl import psrst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    operation_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy_o,
  output logic    done_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_LEAF,
    ST_SET_UP,
    ST_QUERY
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = (operation_i == OP_QUERY) ? ST_QUERY : ST_SET_LEAF;
        end
      end
      ST_SET_LEAF: begin
        cmd_o.set_leaf = 1'b1;
        // drop a write beyond the last leaf
        state_d = sts_i.leaf_ok ? ST_SET_UP : ST_IDLE;
      end
      ST_SET_UP: begin
        cmd_o.set_up = 1'b1;
        if (sts_i.at_root) begin
          state_d = ST_IDLE;
        end
      end
      ST_QUERY: begin
        cmd_o.query = 1'b1;
        if (sts_i.range_done) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = state_q != ST_IDLE;
  assign done_o = done_q;

endmodule
